// File: rtl/backlight_fade_controller_unit_macros.svh
// assertion macros for the backlight fade controller checker
// no dependencies; included by the checker file only
`ifndef BACKLIGHT_FADE_CONTROLLER_UNIT_MACROS_SVH
`define BACKLIGHT_FADE_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define BFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfc_pkg.sv
// shared types and constants for the backlight fade controller
// no dependencies
package bfc_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned BRIGHT_W  = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned TABLE_W   = 64;
    localparam int unsigned IDX_W     = 3;

    localparam logic [IDX_W-1:0]    MAX_LEVEL     = 3'd7;
    localparam logic [BRIGHT_W-1:0] MIN_STEP      = 8'd2;
    localparam logic [TABLE_W-1:0]  TABLE_RESET   = {TABLE_W{1'b1}};
    localparam logic [DELAY_W-1:0]  DELAY_RESET   = 16'd3000;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET  = 8'd255;

    typedef enum logic {
        REG_BRIGHTNESS_TABLE = 1'b0,
        REG_OFF_DELAY_MS     = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [BRIGHT_W-1:0] cur_bright;
        logic                enabled;
        logic                armed;
        logic [TIME_W-1:0]   req_time;
        logic [BRIGHT_W-1:0] written_drive;
    } t_state;

endpackage

// File: rtl/backlight_fade_controller_unit.sv
// Backlight fade controller. One input word is one periodic tick carrying
// the light level, the on/off request and the millisecond time; each tick
// gives one output word with the drive value and a write strobe.
// Input channel: i_valid / o_stall, word taken when i_valid && !o_stall.
// Output channel: o_valid / i_stall, word taken when o_valid && !i_stall.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is the
// packed brightness table, index 1 the off delay in ms.
// A tick is held in the input register, then one pass through the step
// logic updates the kept state and loads the result register. One tick
// per cycle sustained while the receiver does not stall, set by the
// single step from input register to result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more word, then o_stall rises until the result is taken.
// Synchronous active-low reset empties both registers and loads full
// brightness, output enabled, timer disarmed, last written value zero, the
// all-ones table and a 3000 ms off delay.
// Depends on bfc_pkg and bfc_step.
module backlight_fade_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bfc_pkg::LEVEL_W-1:0]     i_light_level,
    input  logic                            i_enable_request,
    input  logic [bfc_pkg::TIME_W-1:0]      i_now_ms,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bfc_pkg::BRIGHT_W-1:0]    o_drive_value,
    output logic                            o_write_strobe,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [bfc_pkg::TABLE_W-1:0]     i_cfg_data
);
    import bfc_pkg::*;

    logic [TABLE_W-1:0]  r_table;
    logic [DELAY_W-1:0]  r_delay;
    t_state              r_state;
    t_state              n_state;

    logic                r_in_valid;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_request;
    logic [TIME_W-1:0]   r_now;

    logic                r_out_valid;
    logic [BRIGHT_W-1:0] r_drive;
    logic                r_strobe;
    logic [BRIGHT_W-1:0] n_drive;
    logic                n_strobe;

    logic                advance;
    logic                take_in;

    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign take_in     = !r_in_valid || advance;
    assign o_stall     = !take_in;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_drive_value  = r_drive;
    assign o_write_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table <= TABLE_RESET;
            r_delay <= DELAY_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BRIGHTNESS_TABLE: r_table <= i_cfg_data;
                REG_OFF_DELAY_MS:     r_delay <= i_cfg_data[DELAY_W-1:0];
                default:              r_table <= r_table;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in && i_valid) begin
            r_level   <= i_light_level;
            r_request <= i_enable_request;
            r_now     <= i_now_ms;
        end
    end

    bfc_step u_step (
        .i_state          (r_state),
        .i_table          (r_table),
        .i_delay          (r_delay),
        .i_light_level    (r_level),
        .i_enable_request (r_request),
        .i_now_ms         (r_now),
        .o_state          (n_state),
        .o_drive_value    (n_drive),
        .o_write_strobe   (n_strobe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_bright    <= BRIGHT_RESET;
            r_state.enabled       <= 1'b1;
            r_state.armed         <= 1'b0;
            r_state.req_time      <= '0;
            r_state.written_drive <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive  <= n_drive;
            r_strobe <= n_strobe;
        end
    end

endmodule

// File: rtl/bfc_step.sv
// one tick of the fade controller: brightness step, off timer, drive value
// depends on bfc_pkg
module bfc_step (
    input  bfc_pkg::t_state                      i_state,
    input  logic [bfc_pkg::TABLE_W-1:0]          i_table,
    input  logic [bfc_pkg::DELAY_W-1:0]          i_delay,
    input  logic [bfc_pkg::LEVEL_W-1:0]          i_light_level,
    input  logic                                 i_enable_request,
    input  logic [bfc_pkg::TIME_W-1:0]           i_now_ms,
    output bfc_pkg::t_state                      o_state,
    output logic [bfc_pkg::BRIGHT_W-1:0]         o_drive_value,
    output logic                                 o_write_strobe
);
    import bfc_pkg::*;

    logic [IDX_W-1:0]    idx;
    logic [BRIGHT_W-1:0] target;
    logic [BRIGHT_W-1:0] diff;
    logic [BRIGHT_W-1:0] step;
    logic [TIME_W-1:0]   elapsed;
    logic [BRIGHT_W-1:0] drive;

    always_comb begin
        idx = (i_light_level > LEVEL_W'(MAX_LEVEL)) ? MAX_LEVEL : i_light_level[IDX_W-1:0];
        target = i_table[idx*BRIGHT_W +: BRIGHT_W];
    end

    // step by half the gap toward target; a zero half snaps to target
    always_comb begin
        diff = (i_state.cur_bright > target) ? (i_state.cur_bright - target)
                                             : (target - i_state.cur_bright);
        step = diff >> 1;
        if (step == '0) begin
            step = MIN_STEP;
        end
        o_state = i_state;
        if (i_state.cur_bright != target) begin
            if (diff < step) begin
                o_state.cur_bright = target;
            end else if (i_state.cur_bright > target) begin
                o_state.cur_bright = i_state.cur_bright - step;
            end else begin
                o_state.cur_bright = i_state.cur_bright + step;
            end
        end

        elapsed = i_now_ms - i_state.req_time;
        if (i_state.enabled != i_enable_request) begin
            if (!i_state.enabled) begin
                o_state.enabled = 1'b1;
                o_state.armed   = 1'b0;
            end else if (!i_state.armed) begin
                o_state.armed    = 1'b1;
                o_state.req_time = i_now_ms;
            end else if (elapsed > TIME_W'(i_delay)) begin
                o_state.enabled = 1'b0;
                o_state.armed   = 1'b0;
            end
        end else begin
            o_state.armed = 1'b0;
        end

        drive = o_state.enabled ? o_state.cur_bright : '0;
        o_write_strobe = (drive != i_state.written_drive);
        o_state.written_drive = drive;
        o_drive_value = drive;
    end

endmodule

// File: rtl/bfc_checker.sv
// port-level checks for the backlight fade controller, bound to the top level
// depends on backlight_fade_controller_unit_macros.svh
module bfc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  logic o_valid,
    input  logic i_stall,
    input  logic [7:0] o_drive_value,
    input  logic o_write_strobe
);
`include "backlight_fade_controller_unit_macros.svh"

    // stalled output word holds
    `BFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_drive_value) && $stable(o_write_strobe), "stalled output word changed")

    // input stall only when both stages are full and the output is stalled
    `BFC_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while pipeline has room")

    // a taken word passes the input register and the output is then valid
    `BFC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_valid && !o_stall, ##1 o_valid, "taken word did not reach the output")

    // reset empties the output
    `BFC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind backlight_fade_controller_unit bfc_checker u_bfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_drive_value  (o_drive_value),
    .o_write_strobe (o_write_strobe)
);

// File: tb/tb_top.sv
// testbench for backlight_fade_controller_unit: random and directed ticks, predicted drive words
// checked in order against the output channel, with register writes between phases
// depends on bfc_pkg and the backlight_fade_controller_unit rtl
module tb_top;
    import bfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               req;
        logic [TIME_W-1:0]  now;
    } t_tick;

    typedef struct {
        logic [BRIGHT_W-1:0] drive;
        logic                strobe;
    } t_drive_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [LEVEL_W-1:0]  i_light_level;
    logic                i_enable_request;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_valid;
    logic                i_stall;
    logic [BRIGHT_W-1:0] o_drive_value;
    logic                o_write_strobe;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_reg            i_cfg_index;
    logic [TABLE_W-1:0]  i_cfg_data;

    t_tick       tick_queue[$];
    t_drive_word drive_expect_q[$];
    t_tick       next_tick;
    t_drive_word exp_word;

    logic        tick_taken;
    logic        hold_sender;
    logic        calm;
    int unsigned cycles;
    int unsigned errors;

    // predictor copy of the block
    logic [TABLE_W-1:0]  lvl_table;
    logic [DELAY_W-1:0]  off_delay;
    logic [BRIGHT_W-1:0] bright;
    logic                lit;
    logic                armed;
    logic [TIME_W-1:0]   armed_at;
    logic [BRIGHT_W-1:0] last_drive;

    logic [TIME_W-1:0]   stim_time;
    logic                req_state;
    logic [LEVEL_W-1:0]  level_state;

    backlight_fade_controller_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_light_level    (i_light_level),
        .i_enable_request (i_enable_request),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive_value    (o_drive_value),
        .o_write_strobe   (o_write_strobe),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 35);
    endfunction

    task automatic predict_drive(input logic [LEVEL_W-1:0] level, input logic req,
                                 input logic [TIME_W-1:0] now);
        int unsigned idx;
        int unsigned target;
        int unsigned gap;
        int unsigned step;
        logic [BRIGHT_W-1:0] drive;
        logic [TIME_W-1:0] elapsed;
        idx = (level > MAX_LEVEL) ? MAX_LEVEL : level;
        target = (lvl_table >> (8 * idx)) & 64'hFF;
        if (bright > target) begin
            gap = bright - target;
            step = gap / 2;
            if (step == 0) step = MIN_STEP;
            bright = (gap < step) ? target : bright - step;
        end else if (bright < target) begin
            gap = target - bright;
            step = gap / 2;
            if (step == 0) step = MIN_STEP;
            bright = (gap < step) ? target : bright + step;
        end
        elapsed = now - armed_at;
        if (lit != req) begin
            if (!lit) begin
                lit = 1'b1;
                armed = 1'b0;
            end else if (!armed) begin
                armed = 1'b1;
                armed_at = now;
            end else if (elapsed > off_delay) begin
                lit = 1'b0;
                armed = 1'b0;
            end
        end else begin
            armed = 1'b0;
        end
        drive = lit ? bright : '0;
        drive_expect_q.push_back('{drive, drive != last_drive});
        last_drive = drive;
    endtask

    // input side: prediction on every accepted tick, register copy on every write
    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            predict_drive(i_light_level, i_enable_request, i_now_ms);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BRIGHTNESS_TABLE: lvl_table = i_cfg_data;
                REG_OFF_DELAY_MS:     off_delay = i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            if (tick_queue.size() > 0 && !hold_sender && !idle_now()) begin
                next_tick = tick_queue.pop_front();
                i_valid <= 1'b1;
                i_light_level <= next_tick.level;
                i_enable_request <= next_tick.req;
                i_now_ms <= next_tick.now;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n ? idle_now() : 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_expect_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected word: drive %0d strobe %0b", o_drive_value,
                             o_write_strobe);
                errors++;
            end else begin
                exp_word = drive_expect_q.pop_front();
                if (o_drive_value !== exp_word.drive || o_write_strobe !== exp_word.strobe)
                begin
                    if (errors < 10)
                        $display("mismatch: drive exp %0d got %0d, strobe exp %0b got %0b",
                                 exp_word.drive, o_drive_value, exp_word.strobe,
                                 o_write_strobe);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[backlight_fade_controller_unit] ERROR");
            $finish;
        end
    end

    task automatic push_tick(input logic [LEVEL_W-1:0] level, input logic req,
                             input logic [TIME_W-1:0] now);
        tick_queue.push_back('{level, req, now});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (tick_queue.size() > 0 || i_valid || drive_expect_q.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [TABLE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // runs of steady requests with advancing time, plus noise words
    task automatic random_ticks(input int n, input int unsigned step_max);
        int unsigned roll;
        logic req;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                stim_time = $urandom;
            end else if (roll < 7) begin
                stim_time = 32'hFFFF_FFFF - $urandom_range(0, step_max * 3);
            end else begin
                stim_time = stim_time + $urandom_range(0, step_max);
            end
            if ($urandom_range(0, 99) < 12) req_state = !req_state;
            req = ($urandom_range(0, 99) < 3) ? !req_state : req_state;
            if ($urandom_range(0, 99) < 25) begin
                level_state = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 9);
            end
            push_tick(level_state, req, stim_time);
        end
    endtask

    function automatic logic [TABLE_W-1:0] random_table();
        return {$urandom, $urandom};
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_light_level = '0;
        i_enable_request = 1'b0;
        i_now_ms = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BRIGHTNESS_TABLE;
        i_cfg_data = '0;
        tick_taken = 1'b0;
        hold_sender = 1'b0;
        calm = 1'b0;
        cycles = 0;
        errors = 0;
        lvl_table = TABLE_RESET;
        off_delay = DELAY_RESET;
        bright = BRIGHT_RESET;
        lit = 1'b1;
        armed = 1'b0;
        armed_at = '0;
        last_drive = '0;
        stim_time = '0;
        req_state = 1'b1;
        level_state = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        push_tick(7, 1'b1, 0);
        push_tick(0, 1'b1, 1);
        wait_idle();

        write_reg(REG_BRIGHTNESS_TABLE, 64'hFF_E0_B4_80_4B_2D_10_00);
        write_reg(REG_OFF_DELAY_MS, 0);
        push_tick(0, 1'b1, 0);
        for (int lv = 1; lv < 8; lv++) push_tick(lv, 1'b1, lv);
        // levels above seven
        push_tick(8, 1'b1, 8);
        push_tick(128, 1'b1, 9);
        push_tick(255, 1'b1, 10);
        // arm, zero elapsed, turn off, stay off, turn on
        push_tick(3, 1'b0, 100);
        push_tick(3, 1'b0, 100);
        push_tick(3, 1'b0, 101);
        push_tick(3, 1'b0, 102);
        push_tick(3, 1'b1, 103);
        // timer cleared by a matching request, then armed afresh
        push_tick(5, 1'b0, 200);
        push_tick(5, 1'b1, 201);
        push_tick(5, 1'b0, 5000);
        push_tick(5, 1'b0, 5001);
        push_tick(5, 1'b1, 5002);
        // time wrap
        push_tick(6, 1'b0, 32'hFFFF_FFFF);
        push_tick(6, 1'b0, 0);
        push_tick(6, 1'b1, 1);
        wait_idle();

        write_reg(REG_BRIGHTNESS_TABLE, random_table());
        write_reg(REG_OFF_DELAY_MS, $urandom_range(0, 300));
        random_ticks(190, 100);
        wait_idle();

        write_reg(REG_BRIGHTNESS_TABLE, '0);
        write_reg(REG_OFF_DELAY_MS, 65535);
        random_ticks(190, 20000);
        wait_idle();

        calm = 1'b1;
        write_reg(REG_BRIGHTNESS_TABLE, {TABLE_W{1'b1}});
        write_reg(REG_OFF_DELAY_MS, 1);
        random_ticks(190, 2);
        wait_idle();
        calm = 1'b0;

        write_reg(REG_OFF_DELAY_MS, $urandom_range(0, 65535));
        write_reg(REG_BRIGHTNESS_TABLE, random_table());
        random_ticks(95, off_delay / 3 + 2);
        while (tick_queue.size() > 0) @(posedge i_clk);
        hold_sender = 1'b1;
        do @(posedge i_clk);
        while (i_valid || drive_expect_q.size() > 0);
        hold_sender = 1'b0;
        random_ticks(95, off_delay / 3 + 2);
        wait_idle();

        write_reg(REG_BRIGHTNESS_TABLE, random_table());
        write_reg(REG_OFF_DELAY_MS, 3000);
        random_ticks(190, 1000);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("[backlight_fade_controller_unit] OK");
        else
            $display("[backlight_fade_controller_unit] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bfc_pkg.sv
rtl/bfc_step.sv
rtl/backlight_fade_controller_unit.sv
rtl/bfc_checker.sv
tb/tb_top.sv
